// ----- src/rgbq_rle_pkg.sv -----
// Shared types, constants and the channel quantizer for the RGB run-length encoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package rgbq_rle_pkg;

  localparam int MAX_RUN      = 127;
  localparam int LEVELS       = 6;
  localparam int CHAN_MAX     = 255;
  localparam int RUN_W        = 7;
  localparam int IDX_W        = 8;
  localparam int CHAN_W       = 8;
  localparam int OFFSET_W     = 6;
  localparam int LEVEL_W      = 3;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              row_last;
  } pixel_t;

  typedef struct packed {
    logic [RUN_W-1:0] run_length;
    logic [IDX_W-1:0] color_index;
    logic             row_end;
    logic             item_last;
  } result_t;

  // Up to two closed runs caused by one pixel: a broken run, then the run closing the row.
  typedef struct packed {
    logic             brk;
    logic [RUN_W-1:0] brk_len;
    logic [IDX_W-1:0] brk_idx;
    logic             row;
    logic [RUN_W-1:0] row_len;
    logic [IDX_W-1:0] row_idx;
  } event_t;

  // ((LEVELS-1)*c)/255 as a count of thresholds passed: level >= k iff (LEVELS-1)*c >= 255*k
  function automatic logic [LEVEL_W-1:0] quantize(input logic [CHAN_W-1:0] c);
    logic [LEVEL_W-1:0] lvl;
    int unsigned        scaled;
    lvl    = '0;
    scaled = (LEVELS - 1) * int'(c);
    for (int k = 1; k < LEVELS; k++) begin
      if (scaled >= CHAN_MAX * k) lvl = lvl + LEVEL_W'(1);
    end
    return lvl;
  endfunction

endpackage

`default_nettype wire

// ----- src/rgbq_rle_front.sv -----
// Front end: takes pixels, forms the palette index and tracks the pending run.
// Emits one event per pixel that closes a run. Depends on rgbq_rle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rgbq_rle_front (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_write,
  input  wire logic [rgbq_rle_pkg::OFFSET_W-1:0]    cfg_data,
  input  wire logic                                 take,
  input  wire rgbq_rle_pkg::pixel_t                 pixel,
  output logic                                      ev_push,
  output rgbq_rle_pkg::event_t                      ev
);
  import rgbq_rle_pkg::*;

  logic [OFFSET_W-1:0] color_offset;
  logic [IDX_W-1:0]    held_index, held_index_next;
  logic [RUN_W-1:0]    run_count, run_count_next;

  logic [IDX_W-1:0]    idx;
  logic [IDX_W-1:0]    held_a;
  logic [RUN_W-1:0]    cnt_a;
  logic [9:0]          idx_sum;

  always_comb begin
    idx_sum = 10'(quantize(pixel.red))
            + 10'(quantize(pixel.green)) * 10'(LEVELS)
            + 10'(quantize(pixel.blue)) * 10'(LEVELS * LEVELS)
            + 10'(color_offset);
    idx = idx_sum[IDX_W-1:0];  // wraps modulo 256

    ev = '0;
    held_a = idx;
    cnt_a  = RUN_W'(1);
    if (run_count != '0) begin
      if (idx == held_index && run_count < RUN_W'(MAX_RUN)) begin
        held_a = held_index;
        cnt_a  = run_count + RUN_W'(1);
      end else begin
        ev.brk     = 1'b1;
        ev.brk_len = run_count;
        ev.brk_idx = held_index;
      end
    end

    held_index_next = held_a;
    run_count_next  = cnt_a;
    if (pixel.row_last) begin
      ev.row         = 1'b1;
      ev.row_len     = cnt_a;
      ev.row_idx     = held_a;
      run_count_next = '0;
    end

    ev_push = take && (ev.brk || ev.row);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      color_offset <= '0;
      held_index   <= '0;
      run_count    <= '0;
    end else begin
      if (cfg_write) color_offset <= cfg_data;
      if (take) begin
        held_index <= held_index_next;
        run_count  <= run_count_next;
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/rgbq_rle_fifo.sv -----
// Short event queue between the front end and the result sequencer.
// Register array read at the head pointer only. Depends on rgbq_rle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rgbq_rle_fifo (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    wr,
  input  wire rgbq_rle_pkg::event_t    wr_data,
  output logic                         full,
  input  wire logic                    rd,
  output logic                         empty,
  output rgbq_rle_pkg::event_t         rd_data
);
  import rgbq_rle_pkg::*;

  event_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_wr, do_rd;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = slots[rd_ptr];

  function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= bump(wr_ptr);
      if (do_rd) rd_ptr <= bump(rd_ptr);
      if (do_wr && !do_rd) count <= count + QCNT_W'(1);
      else if (do_rd && !do_wr) count <= count - QCNT_W'(1);
    end
  end

endmodule

`default_nettype wire

// ----- src/rgbq_rle_back.sv -----
// Back end: expands each queued event into one or two result transactions.
// Drives the output queue interface. Depends on rgbq_rle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rgbq_rle_back (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    ev_empty,
  input  wire rgbq_rle_pkg::event_t    ev,
  output logic                         ev_pop,
  output logic                         empty,
  input  wire logic                    pop,
  output rgbq_rle_pkg::result_t        result
);
  import rgbq_rle_pkg::*;

  // second: the broken run of this event was already delivered
  logic second;
  logic take;
  logic on_brk;

  assign empty  = ev_empty;
  assign take   = pop && !ev_empty;
  assign on_brk = ev.brk && !second;

  always_comb begin
    if (on_brk) begin
      result.run_length  = ev.brk_len;
      result.color_index = ev.brk_idx;
      result.row_end     = 1'b0;
      result.item_last   = !ev.row;
    end else begin
      result.run_length  = ev.row_len;
      result.color_index = ev.row_idx;
      result.row_end     = 1'b1;
      result.item_last   = 1'b1;
    end
  end

  assign ev_pop = take && result.item_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      second <= 1'b0;
    end else if (take) begin
      second <= !result.item_last;
    end
  end

endmodule

`default_nettype wire

// ----- src/rgb_quantize_run_length_encoder.sv -----
// Top level of the RGB quantizer and run-length encoder.
// Instantiates rgbq_rle_front, rgbq_rle_fifo and rgbq_rle_back; uses rgbq_rle_pkg.
//
// Usage:
//   Pixels enter through a queue-style port: a transaction happens on a rising
//   edge with push high and full low. Each channel is reduced to six levels and
//   a palette index plus color_offset is formed; equal indices form runs of at
//   most 127 pixels, and row_last closes the pending run.
//   Results leave through a queue-style port: while empty is low the oldest run
//   is on result; it is taken on a rising edge with pop high.
//   A run closed by a pixel enters the event queue when the pixel is taken
//   and is on result once older events are popped. Throughput: one pixel per
//   cycle while full is low. A pixel that closes two runs needs two pops; a
//   four-entry queue absorbs this; full rises only with four events waiting.
//   When the receiver stalls, pixels are still taken until the queue fills.
//   Reset (rst, synchronous) clears the offset, the pending run and the queue.
//   cfg_write loads color_offset from cfg_data; write only while idle.
`timescale 1ns / 1ps
`default_nettype none

module rgb_quantize_run_length_encoder (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_write,
  input  wire logic [rgbq_rle_pkg::OFFSET_W-1:0]    cfg_data,
  input  wire logic                                 push,
  output logic                                      full,
  input  wire rgbq_rle_pkg::pixel_t                 pixel,
  output logic                                      empty,
  input  wire logic                                 pop,
  output rgbq_rle_pkg::result_t                     result
);
  import rgbq_rle_pkg::*;

  logic   take;
  logic   ev_push, ev_pop, ev_empty;
  event_t ev_in, ev_out;

  assign take = push && !full;

  rgbq_rle_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .take      (take),
    .pixel     (pixel),
    .ev_push   (ev_push),
    .ev        (ev_in)
  );

  rgbq_rle_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (ev_push),
    .wr_data (ev_in),
    .full    (full),
    .rd      (ev_pop),
    .empty   (ev_empty),
    .rd_data (ev_out)
  );

  rgbq_rle_back u_back (
    .clk      (clk),
    .rst      (rst),
    .ev_empty (ev_empty),
    .ev       (ev_out),
    .ev_pop   (ev_pop),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule

`default_nettype wire
